// File: rtl/ptxtok_pkg.sv
// shared types, constants and character classes for the ptx tokenizer
`timescale 1ns / 1ps
package ptxtok_pkg;

  localparam int WB = 16;
  localparam int IDXB = $clog2(WB);
  localparam int OFFSET_BITS = 32;
  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] COL_MAX = 16'hFFFF;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [6:0] K_EOF = 7'd0;
  localparam logic [6:0] K_ERROR = 7'd1;
  localparam logic [6:0] K_LBRACE = 7'd2;
  localparam logic [6:0] K_RBRACE = 7'd3;
  localparam logic [6:0] K_LPAREN = 7'd4;
  localparam logic [6:0] K_RPAREN = 7'd5;
  localparam logic [6:0] K_LBRACK = 7'd6;
  localparam logic [6:0] K_RBRACK = 7'd7;
  localparam logic [6:0] K_LT = 7'd8;
  localparam logic [6:0] K_GT = 7'd9;
  localparam logic [6:0] K_COMMA = 7'd10;
  localparam logic [6:0] K_SEMI = 7'd11;
  localparam logic [6:0] K_PLUS = 7'd12;
  localparam logic [6:0] K_MINUS = 7'd13;
  localparam logic [6:0] K_COLON = 7'd14;
  localparam logic [6:0] K_BANG = 7'd15;
  localparam logic [6:0] K_PIPE = 7'd16;
  localparam logic [6:0] K_AT = 7'd17;
  localparam logic [6:0] K_INT = 7'd18;
  localparam logic [6:0] K_FLOAT = 7'd19;
  localparam logic [6:0] K_REG = 7'd20;
  localparam logic [6:0] K_SREG = 7'd21;
  localparam logic [6:0] K_LABEL = 7'd22;
  localparam logic [6:0] K_IDENT = 7'd23;
  localparam logic [6:0] K_DOT_BASE = 7'd24;
  localparam logic [6:0] K_OP_BASE = 7'd71;

  localparam int NDOT = 47;
  localparam int NOP = 28;
  localparam int NSPEC = 5;

  localparam logic [WB*8-1:0] DOT_WORDS [NDOT] = '{
    ".version", ".target", {".address", "_size"}, ".reg", ".param", ".func",
    ".entry", ".visible", ".extern", ".local", ".shared", ".global",
    ".const", ".align", ".f32", ".f64", ".s32", ".s64", ".u32", ".u64",
    ".u16", ".s16", ".b32", ".b64", ".pred", ".lo", ".hi", ".wide", ".rn",
    ".rz", ".rm", ".rp", ".sync", ".eq", ".ne", ".lt", ".le", ".gt", ".ge",
    ".ls", ".hs", ".equ", ".neu", ".ltu", ".leu", ".gtu", ".geu"};
  localparam logic [WB*8-1:0] OP_WORDS [NOP] = '{
    "add", "sub", "mul", "mad", "fma", "ld", "st", "mov", "cvt", "bra",
    "call", "ret", "setp", "selp", "shl", "shr", "and", "or", "xor", "not",
    "bar", "exit", "min", "max", "abs", "neg", "div", "rem"};
  localparam logic [63:0] SPECIAL [NSPEC] = '{
    "%tid", "%ntid", "%ctaid", "%nctaid", "%laneid"};

  typedef enum logic [14:0] {
    M_IDLE       = 15'b000000000000001,
    M_SLASH      = 15'b000000000000010,
    M_MINUS      = 15'b000000000000100,
    M_LINE       = 15'b000000000001000,
    M_BLOCK      = 15'b000000000010000,
    M_BLOCK_STAR = 15'b000000000100000,
    M_DOT        = 15'b000000001000000,
    M_PCT        = 15'b000000010000000,
    M_IDENT      = 15'b000000100000000,
    M_STR        = 15'b000001000000000,
    M_NUM_FIRST  = 15'b000010000000000,
    M_NUM_DEC    = 15'b000100000000000,
    M_HEX_INT    = 15'b001000000000000,
    M_BIN        = 15'b010000000000000,
    M_HEX_FLT    = 15'b100000000000000
  } mode_t;

  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] offset;
    logic [19:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic        unterminated;
    logic        last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [6:0] punct_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      "<": k = K_LT;
      ">": k = K_GT;
      ",": k = K_COMMA;
      ";": k = K_SEMI;
      "+": k = K_PLUS;
      ":": k = K_COLON;
      "!": k = K_BANG;
      "|": k = K_PIPE;
      "@": k = K_AT;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == LEN_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/ptxtok_core.sv
// scanner state, word buffer and per-byte token classification
`timescale 1ns / 1ps
module ptxtok_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          source_byte,
  input  logic                end_of_source,
  output ptxtok_pkg::result_t res0,
  output ptxtok_pkg::result_t res1,
  output logic [1:0]          res_count
);
  import ptxtok_pkg::*;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [19:0]            line, line_next;
  logic [15:0]            column, column_next;
  logic [OFFSET_BITS-1:0] tok_offset, tok_offset_next;
  logic [19:0]            tok_line, tok_line_next;
  logic [15:0]            tok_column, tok_column_next;
  logic [15:0]            tok_len, tok_len_next;
  logic [7:0]             word_buf [WB];
  logic [7:0]             prev_byte, prev_byte_next;
  logic                   float_seen, float_seen_next;
  logic                   escape, escape_next;

  logic                   buf_we;
  logic [IDXB-1:0]        buf_widx;
  logic [7:0]             buf_wdata;

  logic [WB*8-1:0]        word;
  logic [6:0]             dot_kind, op_kind;
  logic                   special;

  // right-justified copy of the buffered word for table compares
  always_comb begin
    logic [15:0] idx;
    word = '0;
    for (int j = 0; j < WB; j++) begin
      idx = tok_len - 16'd1 - 16'(j);
      if (16'(j) < tok_len) word[8*j +: 8] = word_buf[idx[IDXB-1:0]];
    end
  end

  always_comb begin
    dot_kind = K_IDENT;
    op_kind = K_IDENT;
    if (tok_len <= 16'(WB)) begin
      for (int i = 0; i < NDOT; i++) begin
        if (word == DOT_WORDS[i]) dot_kind = K_DOT_BASE + 7'(i);
      end
      for (int i = 0; i < NOP; i++) begin
        if (word == OP_WORDS[i]) op_kind = K_OP_BASE + 7'(i);
      end
    end
  end

  // prefix match against the special register names
  always_comb begin
    logic hit;
    logic [3:0] plen;
    special = 1'b0;
    for (int s = 0; s < NSPEC; s++) begin
      plen = '0;
      for (int k = 0; k < 8; k++) begin
        if (SPECIAL[s][8*k +: 8] != 8'd0) plen = 4'(k + 1);
      end
      hit = 16'(plen) <= tok_len;
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < plen &&
            word_buf[i] != SPECIAL[s][8*(32'(plen) - 1 - i) +: 8]) hit = 1'b0;
      end
      if (hit) special = 1'b1;
    end
  end

  function automatic result_t mk(input logic [6:0] k, input logic [OFFSET_BITS-1:0] o,
                                 input logic [19:0] l, input logic [15:0] c,
                                 input logic [15:0] n, input logic u);
    result_t r;
    r.kind = k;
    r.offset = 32'(o);
    r.line = l;
    r.column = c;
    r.length = n;
    r.unterminated = u;
    r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic       redo;
    logic       fin_has;
    logic [6:0] fin_kind;
    logic [7:0] b;
    logic       dec_takes;
    result_t    r [2];
    logic [1:0] n;

    b = source_byte;
    redo = 1'b0;
    n = 2'd0;
    r[0] = '0;
    r[1] = '0;
    mode_next = mode;
    offset_next = offset;
    line_next = line;
    column_next = column;
    tok_offset_next = tok_offset;
    tok_line_next = tok_line;
    tok_column_next = tok_column;
    tok_len_next = tok_len;
    prev_byte_next = prev_byte;
    float_seen_next = float_seen;
    escape_next = escape;
    buf_we = 1'b0;
    buf_widx = tok_len[IDXB-1:0];
    buf_wdata = b;

    fin_has = 1'b1;
    case (mode)
      M_SLASH: fin_kind = K_ERROR;
      M_MINUS: fin_kind = K_MINUS;
      M_DOT: fin_kind = dot_kind;
      M_PCT: fin_kind = special ? K_SREG : K_REG;
      M_IDENT: fin_kind = op_kind;
      M_STR: fin_kind = K_IDENT;
      M_NUM_FIRST, M_NUM_DEC: fin_kind = float_seen ? K_FLOAT : K_INT;
      M_HEX_INT, M_BIN: fin_kind = K_INT;
      M_HEX_FLT: fin_kind = K_FLOAT;
      default: begin
        fin_kind = K_EOF;
        fin_has = 1'b0;
      end
    endcase

    dec_takes = is_alnum(b) || b == "." ||
                ((b == "-" || b == "+") && (prev_byte == "e" || prev_byte == "E"));

    if (end_of_source) begin
      if (fin_has) begin
        r[n[0]] = mk(fin_kind, tok_offset, tok_line, tok_column, tok_len, 1'b0);
        n = n + 2'd1;
      end
      r[n[0]] = mk(K_EOF, offset, line, column, 16'd0,
                   (mode == M_BLOCK) || (mode == M_BLOCK_STAR));
      n = n + 2'd1;
      mode_next = M_IDLE;
      offset_next = '0;
      line_next = 20'd1;
      column_next = 16'd1;
      tok_offset_next = '0;
      tok_line_next = 20'd1;
      tok_column_next = 16'd1;
      tok_len_next = '0;
      prev_byte_next = '0;
      float_seen_next = 1'b0;
      escape_next = 1'b0;
    end else begin
      case (mode)
        M_IDLE: redo = 1'b1;
        M_SLASH: begin
          if (b == "/") mode_next = M_LINE;
          else if (b == "*") mode_next = M_BLOCK;
          else redo = 1'b1;
        end
        M_MINUS: begin
          if (is_digit(b)) begin
            mode_next = M_NUM_FIRST;
            float_seen_next = 1'b0;
            tok_len_next = sat_inc16(tok_len);
          end else redo = 1'b1;
        end
        M_LINE: if (b == 8'h0A) mode_next = M_IDLE;
        M_BLOCK: if (b == "*") mode_next = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (b == "/") mode_next = M_IDLE;
          else if (b != "*") mode_next = M_BLOCK;
        end
        M_DOT, M_PCT: begin
          if (is_alnum(b) || b == "_" || (mode == M_PCT && b == ".")) begin
            buf_we = tok_len < 16'(WB);
            tok_len_next = sat_inc16(tok_len);
          end else redo = 1'b1;
        end
        M_IDENT: begin
          if (is_alnum(b) || b == "_" || b == "$") begin
            buf_we = tok_len < 16'(WB);
            tok_len_next = sat_inc16(tok_len);
          end else if (b == ":") begin
            r[0] = mk(K_LABEL, tok_offset, tok_line, tok_column, tok_len, 1'b0);
            n = 2'd1;
            mode_next = M_IDLE;
          end else redo = 1'b1;
        end
        M_STR: begin
          if (escape) begin
            escape_next = 1'b0;
            tok_len_next = sat_inc16(tok_len);
          end else if (b == "\\") begin
            escape_next = 1'b1;
            tok_len_next = sat_inc16(tok_len);
          end else if (b == "\"") begin
            r[0] = mk(K_IDENT, tok_offset, tok_line, tok_column, tok_len, 1'b0);
            n = 2'd1;
            mode_next = M_IDLE;
          end else tok_len_next = sat_inc16(tok_len);
        end
        M_NUM_FIRST, M_NUM_DEC: begin
          if (mode == M_NUM_FIRST && prev_byte == "0" && (b == "x" || b == "X")) begin
            mode_next = M_HEX_INT;
            tok_len_next = sat_inc16(tok_len);
          end else if (mode == M_NUM_FIRST && prev_byte == "0" &&
                       (b == "b" || b == "B")) begin
            mode_next = M_BIN;
            tok_len_next = sat_inc16(tok_len);
          end else if (mode == M_NUM_FIRST && prev_byte == "0" &&
                       (b == "f" || b == "F" || b == "d" || b == "D")) begin
            mode_next = M_HEX_FLT;
            tok_len_next = sat_inc16(tok_len);
          end else begin
            mode_next = M_NUM_DEC;
            if (dec_takes) begin
              tok_len_next = sat_inc16(tok_len);
              if (b == "." || b == "e" || b == "E") float_seen_next = 1'b1;
            end else redo = 1'b1;
          end
        end
        M_HEX_INT, M_HEX_FLT: begin
          if (is_xdigit(b)) tok_len_next = sat_inc16(tok_len);
          else redo = 1'b1;
        end
        M_BIN: begin
          if (b == "0" || b == "1") tok_len_next = sat_inc16(tok_len);
          else redo = 1'b1;
        end
        default: begin
          mode_next = M_IDLE;
          redo = 1'b1;
        end
      endcase

      if (redo) begin
        if (fin_has) begin
          r[0] = mk(fin_kind, tok_offset, tok_line, tok_column, tok_len, 1'b0);
          n = 2'd1;
        end
        mode_next = M_IDLE;
        if (!is_space(b)) begin
          if (b == "/" || b == "-" || b == "." || b == "%" || is_digit(b) ||
              is_alpha(b) || b == "_" || b == "$" || b == "\"") begin
            tok_offset_next = offset;
            tok_line_next = line;
            tok_column_next = column;
            float_seen_next = 1'b0;
            escape_next = 1'b0;
            tok_len_next = 16'd1;
            buf_widx = '0;
            if (b == "/") mode_next = M_SLASH;
            else if (b == "-") mode_next = M_MINUS;
            else if (b == ".") begin
              mode_next = M_DOT;
              buf_we = 1'b1;
            end else if (b == "%") begin
              mode_next = M_PCT;
              buf_we = 1'b1;
            end else if (is_digit(b)) mode_next = M_NUM_FIRST;
            else if (b == "\"") begin
              mode_next = M_STR;
              tok_offset_next = offset + OFFSET_BITS'(1);
              tok_len_next = 16'd0;
            end else begin
              mode_next = M_IDENT;
              buf_we = 1'b1;
            end
          end else begin
            r[n[0]] = mk(punct_kind(b), offset, line, column, 16'd1, 1'b0);
            n = n + 2'd1;
          end
        end
      end

      offset_next = offset + OFFSET_BITS'(1);
      if (b == 8'h0A) begin
        if (line < LINE_MAX) line_next = line + 20'd1;
        column_next = 16'd1;
      end else if (column < COL_MAX) column_next = column + 16'd1;
      prev_byte_next = b;
    end

    if (n == 2'd2) r[1].last = 1'b1;
    else if (n == 2'd1) r[0].last = 1'b1;
    res0 = r[0];
    res1 = r[1];
    res_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      offset <= '0;
      line <= 20'd1;
      column <= 16'd1;
      tok_offset <= '0;
      tok_line <= 20'd1;
      tok_column <= 16'd1;
      tok_len <= '0;
      prev_byte <= '0;
      float_seen <= 1'b0;
      escape <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      offset <= offset_next;
      line <= line_next;
      column <= column_next;
      tok_offset <= tok_offset_next;
      tok_line <= tok_line_next;
      tok_column <= tok_column_next;
      tok_len <= tok_len_next;
      prev_byte <= prev_byte_next;
      float_seen <= float_seen_next;
      escape <= escape_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !end_of_source && buf_we) word_buf[buf_widx] <= buf_wdata;
  end

endmodule

// File: rtl/ptxtok_fifo.sv
// four-entry result queue, up to two writes and one read per cycle
`timescale 1ns / 1ps
module ptxtok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          push_count,
  input  ptxtok_pkg::result_t push0,
  input  ptxtok_pkg::result_t push1,
  input  logic                pop,
  output ptxtok_pkg::result_t head,
  output logic                not_empty,
  output logic                room2,
  output logic [2:0]          count
);
  import ptxtok_pkg::*;

  result_t    mem [4];
  logic [1:0] wptr, rptr;
  logic [1:0] nwr;
  logic       nrd;

  assign nwr = push ? push_count : 2'd0;
  assign nrd = pop && (count != 3'd0);
  assign head = mem[rptr];
  assign not_empty = count != 3'd0;
  assign room2 = count <= 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + nwr;
      rptr <= rptr + 2'(nrd);
      count <= count + 3'(nwr) - 3'(nrd);
    end
  end

  always_ff @(posedge clk) begin
    if (nwr != 2'd0) mem[wptr] <= push0;
    if (nwr == 2'd2) mem[wptr + 2'd1] <= push1;
  end

endmodule

// File: rtl/ptx_assembly_tokenizer.sv
// top level of the ptx tokenizer: scanner plus result queue
//
// channel  direction  handshake            payload
// input    in         in_valid/in_ready    source_byte, end_of_source
// result   out        out_valid/out_ready  token_kind .. last_of_run
//
// one source byte is taken per cycle while in_ready is high; its results enter the queue
// in that same edge and can be taken from the next cycle, one per cycle
// a byte yields zero to two results, so input stalls only when the queue lacks two free slots
// rst is synchronous and returns the scanner to the idle, line one, column one state
`timescale 1ns / 1ps
module ptx_assembly_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  source_byte,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  token_kind,
  output logic [31:0] start_offset,
  output logic [19:0] start_line,
  output logic [15:0] start_column,
  output logic [15:0] lexeme_length,
  output logic        comment_unterminated,
  output logic        last_of_run
);
  import ptxtok_pkg::*;

  logic       take;
  result_t    res0, res1, head;
  logic [1:0] res_count;
  logic       room2;
  logic [2:0] count;

  assign take = in_valid && in_ready;
  assign in_ready = room2;

  ptxtok_core u_core (
    .clk(clk),
    .rst(rst),
    .take(take),
    .source_byte(source_byte),
    .end_of_source(end_of_source),
    .res0(res0),
    .res1(res1),
    .res_count(res_count)
  );

  ptxtok_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(take),
    .push_count(res_count),
    .push0(res0),
    .push1(res1),
    .pop(out_ready),
    .head(head),
    .not_empty(out_valid),
    .room2(room2),
    .count(count)
  );

  assign token_kind = head.kind;
  assign start_offset = head.offset;
  assign start_line = head.line;
  assign start_column = head.column;
  assign lexeme_length = head.length;
  assign comment_unterminated = head.unterminated;
  assign last_of_run = head.last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue over capacity");
  a_eof_result: assert property (@(posedge clk) disable iff (rst)
    take && end_of_source |=> out_valid)
    else $error("end of source produced no result");
  a_unterm_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && comment_unterminated |-> token_kind == K_EOF && last_of_run)
    else $error("unterminated flag on a non-eof result");
`endif

endmodule
